>>> rtl/emfuse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Elevation map point fusion package
// Shared widths, status codes and the queue entry type.
// ----------------------------------------------------------------------------
package emfuse_pkg;

	localparam int SubmapsPerSide = 16;
	localparam int SubmapCells = 32;
	localparam int MaxSubmaps = 16;

	localparam logic [16:0] CellSizeReset = 17'd6554;
	localparam logic [16:0] NoiseReset = 17'd655;
	localparam logic [3:0] RootReset = 4'd8;

	localparam logic [1:0] REG_CELL_SIZE = 2'd0;
	localparam logic [1:0] REG_NOISE = 2'd1;
	localparam logic [1:0] REG_ROOT = 2'd2;

	localparam logic [1:0] ST_UPDATED = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_NO_SLOT = 2'd2;

	// Classified point handed from the front part to the back part.
	typedef struct packed {
		logic [1:0] status;
		logic [3:0] slot;
		logic [4:0] row;
		logic [4:0] col;
		logic [31:0] z;
	} fuse_job_t;

endpackage
`default_nettype wire

>>> rtl/emfuse_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module emfuse_divider #(
	parameter int NW = 64,
	parameter int DW = 40
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [NW-1:0] num,
	input wire logic [DW-1:0] den,
	output logic busy,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] quo_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0] trial;
	logic [DW+1:0] diff;

	assign busy = (cnt_q != '0);
	assign quo = quo_q;
	assign trial = {rem_q[DW-1:0], quo_q[NW-1]};
	assign diff = {1'b0, trial} - {2'b00, den_q};

	// Shift in one numerator bit per cycle and subtract when possible.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/emfuse_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Point binning front end
// Bins x and y into a submap and cell and assigns submap slots.
// ----------------------------------------------------------------------------
module emfuse_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [31:0] point_x,
	input wire logic [31:0] point_y,
	input wire logic [31:0] point_z,
	input wire logic [16:0] cell_size,
	input wire logic [3:0] root_submap_index,
	output logic job_valid,
	output emfuse_pkg::fuse_job_t job,
	input wire logic job_full
);
	import emfuse_pkg::*;

	typedef enum logic [6:0] {
		F_CLR  = 7'b0000001,
		F_IDLE = 7'b0000010,
		F_DIVX = 7'b0000100,
		F_DIVY = 7'b0001000,
		F_SLOT = 7'b0010000,
		F_LOOK = 7'b0100000,
		F_PUSH = 7'b1000000
	} fstate_t;

	fstate_t state_q;
	logic [7:0] clr_q;
	logic [31:0] y_q, z_q;
	logic [16:0] cs_q;
	logic [3:0] root_q;
	logic signed [39:0] subx_q;
	logic [63:0] subx_n_q, ny_n_q;
	logic [4:0] gx_q, gy_q;
	logic [1:0] st_q;
	logic [3:0] slot_q;
	logic [4:0] tab_mem [256];
	logic [4:0] tab_rd_q;
	logic [4:0] used_q;

	logic [16:0] cs_in, cs_use;
	logic [31:0] ax_p;
	logic [22:0] len;
	logic [63:0] n_pos;
	logic div_start, div_busy;
	logic [63:0] div_quo;
	logic signed [39:0] sub_k;
	logic [63:0] npos_ax;
	logic [24:0] rem;
	logic [4:0] cell_idx;
	logic signed [40:0] cxs, cys;
	logic [7:0] tab_idx;
	logic in_map;

	// A cell size of zero acts as one; the live register is used at accept.
	assign cs_in = (cell_size == '0) ? 17'd1 : cell_size;
	assign cs_use = (state_q == F_IDLE) ? cs_in : cs_q;

	// Axis binning: n = 2p + L, shifted by 2L*2^26 so it stays positive.
	assign len = 23'(cs_use) * 23'(SubmapCells);
	assign ax_p = (state_q == F_IDLE) ? point_x : y_q;
	assign n_pos = 64'($signed({{32{ax_p[31]}}, ax_p}) * 2) + 64'(len)
		+ (64'(len) << 27);
	assign div_start = (state_q == F_IDLE && in_valid)
		|| (state_q == F_DIVX && !div_busy);

	emfuse_divider #(.NW(64), .DW(24)) u_bin_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(n_pos), .den({len, 1'b0}), .busy(div_busy), .quo(div_quo)
	);

	assign npos_ax = (state_q == F_DIVX) ? subx_n_q : ny_n_q;
	assign sub_k = $signed(div_quo[39:0]) - 40'sd67108864;
	// Remainder is below 2L, so only its low bits are formed.
	assign rem = npos_ax[24:0] - 25'(div_quo[24:0] * {len, 1'b0});
	always_comb begin
		cell_idx = 5'(SubmapCells - 1);
		for (int i = SubmapCells - 1; i >= 0; i--) begin
			if (rem < 25'(i + 1) * {7'd0, cs_q, 1'b0}) cell_idx = 5'(i);
		end
	end

	assign cxs = 41'(subx_q) + 41'(root_q);
	assign cys = 41'(sub_k) + 41'(root_q);
	assign tab_idx = {cxs[3:0], cys[3:0]};
	assign in_map = !(cxs < 0 || cxs >= SubmapsPerSide || cys < 0
		|| cys >= SubmapsPerSide);

	assign in_stall = (state_q != F_IDLE);
	assign job_valid = (state_q == F_PUSH);
	assign job = '{status: st_q, slot: slot_q, row: gx_q, col: gy_q, z: z_q};

	// Clear the slot table after reset, then sequence one point through both
	// axis divisions and the slot lookup.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_CLR;
			clr_q <= '0;
			used_q <= '0;
		end else begin
			case (state_q)
				F_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= F_IDLE;
				end
				F_IDLE: if (in_valid) state_q <= F_DIVX;
				F_DIVX: if (!div_busy) state_q <= F_DIVY;
				F_DIVY: if (!div_busy) state_q <= F_SLOT;
				F_SLOT: state_q <= F_LOOK;
				F_LOOK: begin
					state_q <= F_PUSH;
					if (in_map && !tab_rd_q[4] && used_q < 5'(MaxSubmaps)) begin
						used_q <= used_q + 1'b1;
					end
				end
				F_PUSH: if (!job_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_CLR) tab_mem[clr_q] <= '0;
		if (state_q == F_IDLE) begin
			y_q <= point_y;
			z_q <= point_z;
			cs_q <= cs_in;
			root_q <= root_submap_index;
			subx_n_q <= n_pos;
		end
		if (state_q == F_DIVX && !div_busy) begin
			subx_q <= sub_k;
			gx_q <= cell_idx;
			ny_n_q <= n_pos;
		end
		if (state_q == F_DIVY && !div_busy) begin
			gy_q <= cell_idx;
		end
		// Table entry holds a valid bit over the slot number.
		if (state_q == F_SLOT) begin
			tab_rd_q <= tab_mem[tab_idx];
		end
		if (state_q == F_LOOK) begin
			if (!in_map) begin
				st_q <= ST_OUTSIDE;
			end else if (tab_rd_q[4]) begin
				st_q <= ST_UPDATED;
				slot_q <= tab_rd_q[3:0];
			end else if (used_q < 5'(MaxSubmaps)) begin
				st_q <= ST_UPDATED;
				slot_q <= used_q[3:0];
				tab_mem[tab_idx] <= {1'b1, used_q[3:0]};
			end else begin
				st_q <= ST_NO_SLOT;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/emfuse_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Cell fusion back end
// Reads a cell, applies the scalar Kalman update and writes it back.
// ----------------------------------------------------------------------------
module emfuse_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic job_valid,
	input wire emfuse_pkg::fuse_job_t job,
	output logic job_pop,
	input wire logic [16:0] measurement_noise,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [3:0] submap_slot,
	output logic [4:0] cell_row,
	output logic [4:0] cell_col,
	output logic [15:0] observe_count,
	output logic [31:0] elevation,
	output logic [31:0] variance
);
	import emfuse_pkg::*;

	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_CLR  = 7'b0000010,
		B_READ = 7'b0000100,
		B_MUL  = 7'b0001000,
		B_LOAD = 7'b0010000,
		B_DIV  = 7'b0100000,
		B_OUT  = 7'b1000000
	} bstate_t;

	bstate_t state_q;
	logic [13:0] clr_q;
	logic [15:0] cnt_mem [16384];
	logic [31:0] mu_mem [16384];
	logic [16:0] var_mem [16384];
	logic [15:0] cnt_rd_q;
	logic [31:0] mu_rd_q;
	logic [16:0] var_rd_q;
	fuse_job_t job_q;
	logic [16:0] noise_q;
	logic [13:0] addr;
	logic signed [32:0] diff;
	logic signed [50:0] prod_s1;
	logic [33:0] vprod_s1;
	logic [17:0] sum;
	logic neg_q;
	logic div_start, div_busy, div2_busy;
	logic [63:0] div_num, div_quo;
	logic [63:0] div2_quo;
	logic [50:0] mag;
	logic [15:0] cnt_new;
	logic [31:0] mu_new;
	logic [31:0] var_new;

	assign addr = {job_q.slot, job_q.row, job_q.col};
	assign sum = 18'(var_rd_q) + 18'(noise_q);
	assign diff = $signed({job_q.z[31], job_q.z}) - $signed({mu_rd_q[31], mu_rd_q});
	assign job_pop = (state_q == B_IDLE) && job_valid;

	assign mag = prod_s1[50] ? 51'(-prod_s1) : 51'(prod_s1);
	// Floor of a negative quotient: round the magnitude up.
	assign div_num = 64'(mag) + (neg_q ? 64'(sum) - 64'd1 : 64'd0);
	assign div_start = (state_q == B_LOAD);

	emfuse_divider #(.NW(64), .DW(18)) u_mu_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(sum), .busy(div_busy), .quo(div_quo)
	);
	emfuse_divider #(.NW(64), .DW(18)) u_var_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(64'(vprod_s1)),
		.den(sum), .busy(div2_busy), .quo(div2_quo)
	);

	always_comb begin
		cnt_new = (cnt_rd_q == 16'hFFFF) ? cnt_rd_q : cnt_rd_q + 1'b1;
		if (cnt_rd_q == '0) begin
			mu_new = job_q.z;
			var_new = 32'(noise_q);
		end else if (sum == '0) begin
			mu_new = mu_rd_q;
			var_new = '0;
		end else begin
			mu_new = mu_rd_q + (neg_q ? 32'(-div_quo[31:0]) : div_quo[31:0]);
			var_new = div2_quo[31:0];
		end
	end

	// Control sequence, with a clearing pass over the counts after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLR;
			clr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= B_IDLE;
				end
				B_IDLE: if (job_valid) state_q <= B_READ;
				B_READ: state_q <= (job_q.status == ST_UPDATED) ? B_MUL : B_OUT;
				B_MUL: state_q <= B_LOAD;
				B_LOAD: state_q <= B_DIV;
				B_DIV: if (!div_busy && !div2_busy) state_q <= B_OUT;
				B_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			if (out_valid && !out_stall && state_q != B_OUT) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_CLR) cnt_mem[clr_q] <= '0;
		if (job_pop) begin
			job_q <= job;
			noise_q <= measurement_noise;
		end
		if (state_q == B_READ) begin
			cnt_rd_q <= cnt_mem[addr];
			mu_rd_q <= mu_mem[addr];
			var_rd_q <= var_mem[addr];
		end
		if (state_q == B_MUL) begin
			prod_s1 <= diff * $signed({1'b0, var_rd_q});
			vprod_s1 <= var_rd_q * noise_q;
			neg_q <= diff[32] && var_rd_q != '0;
		end
		if (state_q == B_OUT && (!out_valid || !out_stall)) begin
			status <= job_q.status;
			if (job_q.status == ST_UPDATED) begin
				cnt_mem[addr] <= cnt_new;
				mu_mem[addr] <= mu_new;
				var_mem[addr] <= var_new[16:0];
				submap_slot <= job_q.slot;
				cell_row <= job_q.row;
				cell_col <= job_q.col;
				observe_count <= cnt_new;
				elevation <= mu_new;
				variance <= var_new;
			end else begin
				submap_slot <= '0;
				cell_row <= '0;
				cell_col <= '0;
				observe_count <= '0;
				elevation <= '0;
				variance <= '0;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/elevation_map_point_fusion_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Elevation map point fusion core
// Bins points into submap cells and fuses their heights per cell.
// ----------------------------------------------------------------------------
// Usage: points arrive on the in channel (in_valid/in_stall, point_x/y/z);
// one result per point leaves on the out channel (out_valid/out_stall).
// The front part runs two 64-step binning divisions and a slot table lookup
// (F_SLOT reads the table, F_LOOK assigns the slot), one point at a time.
// A one-entry queue decouples it from the back part, which reads the cell,
// runs two parallel 64-step fusion divisions and writes the cell back
// (a point outside the map or without a free slot skips the divisions).
// Sustained rate is set by the front part, which takes no new point until
// it has pushed the last one to the queue. After reset the front part
// clears its 256-entry slot table, holding in_stall high while it does so,
// and the back part clears the 16384 cell counts, one per cycle, before
// taking its first transaction; points queue in front meanwhile.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while idle, which the block itself does not enforce.
// When the receiver stalls, the result holds and the back part waits.
// ----------------------------------------------------------------------------
module elevation_map_point_fusion_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [16:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [31:0] point_x,
	input wire logic [31:0] point_y,
	input wire logic [31:0] point_z,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [3:0] submap_slot,
	output logic [4:0] cell_row,
	output logic [4:0] cell_col,
	output logic [15:0] observe_count,
	output logic [31:0] elevation,
	output logic [31:0] variance
);
	import emfuse_pkg::*;

	logic [16:0] cell_size_q, noise_q;
	logic [3:0] root_q;
	logic f_valid, q_full, pop;
	fuse_job_t f_job, q_job_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= CellSizeReset;
			noise_q <= NoiseReset;
			root_q <= RootReset;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CELL_SIZE: cell_size_q <= cfg_data;
				REG_NOISE: noise_q <= cfg_data;
				REG_ROOT: root_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	emfuse_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.cell_size(cell_size_q), .root_submap_index(root_q),
		.job_valid(f_valid), .job(f_job), .job_full(q_full)
	);

	// One-entry queue between the two parts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) q_full <= 1'b0;
		else if (f_valid && !q_full) q_full <= 1'b1;
		else if (pop) q_full <= 1'b0;
	end
	always_ff @(posedge clk) if (f_valid && !q_full) q_job_q <= f_job;

	emfuse_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(q_full), .job(q_job_q),
		.job_pop(pop), .measurement_noise(noise_q),
		.out_valid(out_valid), .out_stall(out_stall), .status(status),
		.submap_slot(submap_slot), .cell_row(cell_row), .cell_col(cell_col),
		.observe_count(observe_count), .elevation(elevation), .variance(variance)
	);
endmodule
`default_nettype wire

>>> verif/tb_elevation_map_point_fusion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevation map point fusion core testbench
// Sends points through the core under several register settings, predicts
// each result (submap binning, slot allocation, per-cell Kalman fusion) and
// checks every returned transaction field by field, in order.
// ----------------------------------------------------------------------------
module tb_elevation_map_point_fusion_core;
	import emfuse_pkg::*;

	typedef struct {
		logic [1:0] status;
		logic [3:0] slot;
		logic [4:0] row;
		logic [4:0] col;
		logic [15:0] count;
		logic [31:0] elev;
		logic [31:0] vari;
	} fusion_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		bit typed;
		fusion_t want;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_CELL_SIZE;
	logic [16:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] point_x = '0;
	logic [31:0] point_y = '0;
	logic [31:0] point_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [3:0] submap_slot;
	logic [4:0] cell_row;
	logic [4:0] cell_col;
	logic [15:0] observe_count;
	logic [31:0] elevation;
	logic [31:0] variance;

	// Shadow of the map state and registers.
	logic [16:0] cell_size_q = CellSizeReset;
	logic [16:0] noise_q = NoiseReset;
	logic [3:0] root_q = RootReset;
	bit submap_owned [SubmapsPerSide*SubmapsPerSide];
	int submap_slot_of [SubmapsPerSide*SubmapsPerSide];
	int slots_taken = 0;
	int owned_submaps [$];
	logic [15:0] cell_count [MaxSubmaps*SubmapCells*SubmapCells];
	logic [31:0] cell_height [MaxSubmaps*SubmapCells*SubmapCells];
	logic [31:0] cell_var [MaxSubmaps*SubmapCells*SubmapCells];

	point_row_t rows [$];
	fusion_t pending_fusions [$];
	int errors = 0;
	int unsigned cyc = 0;

	elevation_map_point_fusion_core dut (.*);

	always #5 clk = ~clk;

	initial begin
		#30ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic longint floor_quot(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0)
			q--;
		return q;
	endfunction

	// Appends one directed stimulus row.
	function automatic void add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			bit typed, fusion_t want);
		rows.insert(rows.size(), point_row_t'{x, y, z, typed, want});
	endfunction

	// Splits one coordinate into a submap offset and a cell index.
	function automatic void split_axis(longint p, longint cs, output longint sub,
			output longint cell_idx);
		longint len;
		longint n;
		len = SubmapCells * cs;
		n = 2 * p + len;
		sub = floor_quot(n, 2 * len);
		cell_idx = (n - sub * 2 * len) / (2 * cs);
		if (cell_idx >= SubmapCells)
			cell_idx = SubmapCells - 1;
	endfunction

	// Predicts one point's result and updates the shadow map.
	task automatic fuse_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			output fusion_t r);
		longint cs, sx, sy, gx, gy, cx, cy, mu, m0, sig, sum;
		int tab, slot, ci;
		logic [31:0] vout;
		r = '{default: '0};
		cs = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
		split_axis(longint'(signed'(px)), cs, sx, gx);
		split_axis(longint'(signed'(py)), cs, sy, gy);
		cx = sx + root_q;
		cy = sy + root_q;
		if (cx < 0 || cx >= SubmapsPerSide || cy < 0 || cy >= SubmapsPerSide) begin
			r.status = ST_OUTSIDE;
			return;
		end
		tab = int'(cx * SubmapsPerSide + cy);
		if (!submap_owned[tab]) begin
			if (slots_taken >= MaxSubmaps) begin
				r.status = ST_NO_SLOT;
				return;
			end
			submap_owned[tab] = 1'b1;
			submap_slot_of[tab] = slots_taken;
			slots_taken++;
			owned_submaps.insert(owned_submaps.size(), tab);
		end
		slot = submap_slot_of[tab];
		ci = slot * SubmapCells * SubmapCells + int'(gx) * SubmapCells + int'(gy);
		if (cell_count[ci] == 0) begin
			mu = longint'(signed'(pz));
			vout = 32'(noise_q);
		end else begin
			m0 = longint'(signed'(cell_height[ci]));
			sig = longint'(cell_var[ci] & 32'h1FFFF);
			sum = sig + noise_q;
			if (sum == 0) begin
				mu = m0;
				vout = '0;
			end else begin
				mu = m0 + floor_quot((longint'(signed'(pz)) - m0) * sig, sum);
				vout = 32'((sig * noise_q) / sum);
			end
		end
		if (cell_count[ci] != 16'hFFFF)
			cell_count[ci]++;
		cell_height[ci] = mu[31:0];
		cell_var[ci] = vout;
		r.status = ST_UPDATED;
		r.slot = slot[3:0];
		r.row = gx[4:0];
		r.col = gy[4:0];
		r.count = cell_count[ci];
		r.elev = mu[31:0];
		r.vari = vout;
	endtask

	// Offers one point and waits until the transaction is accepted.
	task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			bit typed, fusion_t want);
		fusion_t r;
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		do
			@(posedge clk);
		while (in_stall);
		fuse_point(px, py, pz, r);
		if (typed)
			pending_fusions.insert(pending_fusions.size(), want);
		else
			pending_fusions.insert(pending_fusions.size(), r);
	endtask

	// Drops the valid for a random gap at the end of a burst.
	task automatic pace(inout int burst);
		if (burst > 0) begin
			burst--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			burst = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
		end
	endtask

	// Writes all three registers once the core has drained.
	task automatic write_regs(logic [16:0] cs, logic [16:0] noise, logic [3:0] root);
		in_valid <= 1'b0;
		wait (pending_fusions.size() == 0);
		repeat (300) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_CELL_SIZE;
		cfg_data <= cs;
		@(posedge clk);
		cfg_index <= REG_NOISE;
		cfg_data <= noise;
		@(posedge clk);
		cfg_index <= REG_ROOT;
		cfg_data <= 17'(root);
		@(posedge clk);
		cfg_we <= 1'b0;
		cell_size_q = cs;
		noise_q = noise;
		root_q = root;
	endtask

	// Picks a point, about half the time in owned submaps on a few cells so they fuse often.
	task automatic pick_point(output logic [31:0] px, output logic [31:0] py);
		longint cs, len, cx, cy, gx, gy, wx, wy;
		int mode, tab;
		cs = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
		len = SubmapCells * cs;
		mode = $urandom_range(99);
		if (mode < 15) begin
			px = $urandom;
			py = $urandom;
		end else begin
			if (mode < 65 && owned_submaps.size() > 0) begin
				tab = owned_submaps[$urandom_range(owned_submaps.size() - 1)];
				cx = tab / SubmapsPerSide;
				cy = tab % SubmapsPerSide;
				gx = $urandom_range(3);
				gy = $urandom_range(3);
			end else if (mode < 88) begin
				cx = $urandom_range(SubmapsPerSide - 1);
				cy = $urandom_range(SubmapsPerSide - 1);
				gx = $urandom_range(SubmapCells - 1);
				gy = $urandom_range(SubmapCells - 1);
			end else begin
				cx = longint'($urandom_range(SubmapsPerSide + 3)) - 2;
				cy = longint'($urandom_range(SubmapsPerSide + 3)) - 2;
				gx = $urandom_range(SubmapCells - 1);
				gy = $urandom_range(SubmapCells - 1);
			end
			wx = (cx - root_q) * len - len / 2 + gx * cs + $urandom_range(int'(cs - 1));
			wy = (cy - root_q) * len - len / 2 + gy * cs + $urandom_range(int'(cs - 1));
			px = wx[31:0];
			py = wy[31:0];
		end
	endtask

	// Receiver stall pattern, changing character as bits 9:8 of the cycle counter advance.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		case (cyc[9:8])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(3) == 0);
			2'd2: out_stall <= ($urandom_range(3) != 0);
			default: out_stall <= cyc[4];
		endcase
	end

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	// Compares every result transaction with the oldest prediction.
	always @(posedge clk) begin
		fusion_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_fusions.size() == 0) begin
				$error("result transaction with no point outstanding");
				errors++;
			end else begin
				e = pending_fusions.pop_front();
				check_field("status", 32'(e.status), 32'(status));
				check_field("submap_slot", 32'(e.slot), 32'(submap_slot));
				check_field("cell_row", 32'(e.row), 32'(cell_row));
				check_field("cell_col", 32'(e.col), 32'(cell_col));
				check_field("observe_count", 32'(e.count), 32'(observe_count));
				check_field("elevation", e.elev, elevation);
				check_field("variance", e.vari, variance);
			end
		end
	end

	initial begin
		fusion_t off;
		fusion_t first;
		logic [31:0] rx, ry;
		int burst;
		logic [16:0] set_cs [5];
		logic [16:0] set_noise [5];
		logic [3:0] set_root [5];

		off = '{default: '0};
		off.status = ST_OUTSIDE;
		first = '{status: ST_UPDATED, slot: 4'd0, row: 5'd16, col: 5'd16, count: 16'd1,
			elev: 32'h12345678, vari: 32'd655};

		// Directed points at the reset settings: origin cell, map edges, extremes.
		add_row(32'd0, 32'd0, 32'h12345678, 1'b1, first);
		add_row(32'd0, 32'd0, 32'h12345678, 1'b0, off);
		add_row(32'd0, 32'd0, 32'h80000000, 1'b0, off);
		add_row(32'd0, 32'd0, 32'h7FFFFFFF, 1'b0, off);
		add_row(32'h80000000, 32'd0, 32'd5, 1'b1, off);
		add_row(32'h7FFFFFFF, 32'd0, 32'd5, 1'b1, off);
		add_row(32'd0, 32'h80000000, 32'd5, 1'b1, off);
		add_row(32'd0, 32'h7FFFFFFF, 32'd5, 1'b1, off);
		add_row(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, off);
		add_row(-32'sd1782688, 32'd0, 32'd100, 1'b0, off);
		add_row(-32'sd1782689, 32'd0, 32'd100, 1'b1, off);
		add_row(32'd1572959, 32'd1572959, 32'd100, 1'b0, off);
		add_row(32'd1572960, 32'd0, 32'd100, 1'b1, off);
		add_row(32'd0, 32'd1572960, 32'd100, 1'b1, off);
		add_row(32'd1572959, 32'd1572959, 32'hFFFF0000, 1'b0, off);
		add_row(-32'sd1782688, -32'sd1782688, 32'h00010000, 1'b0, off);

		// Settings per phase; cell size and noise of zero are among them.
		set_cs = '{17'd6554, 17'd1, 17'd0, 17'h1FFFF, 17'd65536};
		set_noise = '{17'd655, 17'd1, 17'd0, 17'h1FFFF, 17'd65536};
		set_root = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd12};

		foreach (submap_owned[i]) submap_owned[i] = 1'b0;
		foreach (cell_count[i]) cell_count[i] = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst = 0;
		foreach (rows[i]) begin
			send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].want);
			pace(burst);
		end

		for (int ph = 0; ph < 5; ph++) begin
			write_regs(set_cs[ph], set_noise[ph], set_root[ph]);
			for (int k = 0; k < 240; k++) begin
				pick_point(rx, ry);
				send_point(rx, ry, ($urandom_range(1) == 0) ? $urandom
					: 32'($urandom_range(32'h40000)) - 32'h20000, 1'b0, off);
				pace(burst);
			end
		end
		in_valid <= 1'b0;

		wait (pending_fusions.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> elevation_map_point_fusion_core.f
rtl/emfuse_pkg.sv
rtl/emfuse_divider.sv
rtl/emfuse_front.sv
rtl/emfuse_back.sv
rtl/elevation_map_point_fusion_core.sv
verif/tb_elevation_map_point_fusion_core.sv
